// ===== src/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg: shared types, constants and functions of the suppression gain block
// Holds the configuration and result records and the fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ssg_pkg;

  typedef enum logic [2:0] {
    CFG_MIN_GAIN_SPEECH  = 3'd0,
    CFG_MIN_GAIN_DEFAULT = 3'd1,
    CFG_MIN_GAIN_NOISE   = 3'd2,
    CFG_NOISE_DECAY      = 3'd3,
    CFG_VARIANCE_DECAY   = 3'd4,
    CFG_SIGMA_SCALE      = 3'd5,
    CFG_RELEASE_WEIGHT   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] min_gain_speech;
    logic [15:0] min_gain_default;
    logic [15:0] min_gain_noise;
    logic [15:0] noise_decay;
    logic [15:0] variance_decay;
    logic [15:0] sigma_scale;
    logic [15:0] release_weight;
  } ssg_cfg_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [8:0]  bin_index;
    logic        last;
  } ssg_res_t;

  typedef logic [15:0][31:0] exp_tab_t;

  localparam logic [15:0] CONF_SPEECH  = 16'd52429;
  localparam logic [15:0] CONF_NOISE   = 16'd19660;
  localparam logic [15:0] CONF_HALF    = 16'd32768;
  localparam logic [16:0] ALPHA_FAST   = 17'd19661;
  localparam logic [16:0] ALPHA_SLOW   = 17'd9830;
  localparam logic [15:0] GAIN_ONE     = 16'd32768;
  localparam logic [16:0] Q16_ONE      = 17'h10000;
  localparam logic [15:0] POW_EXP      = 16'd60293;
  localparam logic [63:0] VAR_EPS      = 64'd110;
  localparam logic [16:0] RECIP3       = 17'd43691;
  localparam logic [31:0] MEAN_RESET   = 32'd1;
  localparam logic [15:0] CFG_RST_MGS  = 16'd27853;
  localparam logic [15:0] CFG_RST_MGD  = 16'd8192;
  localparam logic [15:0] CFG_RST_MGN  = 16'd4915;
  localparam logic [15:0] CFG_RST_ND   = 16'd64225;
  localparam logic [15:0] CFG_RST_VD   = 16'd64881;
  localparam logic [15:0] CFG_RST_SIG  = 16'd6144;
  localparam logic [15:0] CFG_RST_RW   = 16'd62915;

  // Floor square root, used only to build constant tables.
  function automatic logic [63:0] isqrt64_f(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-(k+1)) in Q2.30, each entry the floor root of the one before.
  function automatic exp_tab_t exp_table();
    exp_tab_t    t;
    logic [63:0] c;
    c = isqrt64_f(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      t[k] = c[31:0];
      c = isqrt64_f(c << 30);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/ssg_if.sv =====
// ----------------------------------------------------------------------------
// ssg_if: valid/ready channels of the suppression gain block
// Input channel carries one bin per beat, output channel one gain per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] magnitude;
  logic [15:0] voice_confidence;
  modport source (output valid, output magnitude, output voice_confidence, input ready);
  modport sink (input valid, input magnitude, input voice_confidence, output ready);
endinterface

interface ssg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain;
  logic [8:0]  bin_index;
  logic        last;
  modport source (output valid, output gain, output bin_index, output last, input ready);
  modport sink (input valid, input gain, input bin_index, input last, output ready);
endinterface

`default_nettype wire

// ===== src/ssg_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssg_sqrt: iterative 64-bit floor square root
// Resolves one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x_in,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] x_r;
  logic [63:0] r_r;
  logic [63:0] b_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] rb;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      r_r <= '0;
      b_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (x_r >= rb) begin
        x_r <= x_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

`default_nettype wire

// ===== src/ssg_div.sv =====
// ----------------------------------------------------------------------------
// ssg_div: restoring divider for the 16-bit ratio (num << 16) / den
// Requires num < den; one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [15:0]      quot
);

  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [15:0] q_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem2;
  logic        fits;

  assign rem2 = {rem_r[31:0], 1'b0};
  assign fits = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem2 - {1'b0, den_r} : rem2;
      q_r   <= {q_r[14:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ===== src/ssg_core.sv =====
// ----------------------------------------------------------------------------
// ssg_core: sequencer, shared multiplier and per-bin state memories
// Steps one bin through noise update, floor, ratio, power law and smoothing.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_core #(
  parameter int NUM_BINS = 257
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [31:0]      mag_in,
  input  wire logic [15:0]      conf_in,
  input  wire ssg_pkg::ssg_cfg_t cfg,
  input  wire logic [1:0]       space,
  output logic                  ready,
  output logic                  push,
  output logic [1:0]            push_cnt,
  output ssg_pkg::ssg_res_t     res [2]
);

  localparam int BW = $clog2(NUM_BINS);
  localparam logic [BW-1:0] LAST_BIN = BW'(NUM_BINS - 1);
  localparam ssg_pkg::exp_tab_t EXP_C = ssg_pkg::exp_table();

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_LD, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
    S_SQS, S_SQW, S_FL, S_DVW, S_LG1, S_LG2, S_PW0, S_PW1, S_EX1, S_EX2, S_PW2,
    S_TP1, S_TP2, S_TP3, S_WN, S_WD, S_PUSH
  } state_t;

  state_t            state_r;
  logic [BW-1:0]     clr_r;
  logic [BW-1:0]     bin_r;
  logic [31:0]       mag_r;
  logic [15:0]       conf_r;
  logic [31:0]       mean_r;
  logic [63:0]       var_r;
  logic [63:0]       d2_r;
  logic [15:0]       held_r;
  logic [64:0]       tmp_r;
  logic [64:0]       prod_r;
  logic [31:0]       x_r;
  logic [19:0]       lg_r;
  logic [19:0]       t_r;
  logic [31:0]       v_r;
  logic [3:0]        k_r;
  logic [15:0]       target_r;
  logic [15:0]       g_r;
  logic [15:0]       wp0_r;
  logic [15:0]       wp1_r;
  ssg_pkg::ssg_res_t res_r [2];
  logic [1:0]        rcnt_r;

  logic [31:0] mean_mem [NUM_BINS];
  logic [63:0] var_mem [NUM_BINS];
  logic [15:0] held_mem [NUM_BINS];
  logic [31:0] mean_q;
  logic [63:0] var_q;
  logic [15:0] held_q;

  logic          mem_we;
  logic [BW-1:0] mem_wa;
  logic [31:0]   mean_wd;
  logic [63:0]   var_wd;
  logic [15:0]   held_wd;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;

  logic        noisy;
  logic [15:0] min_g;
  logic [15:0] mg_raw;
  logic [31:0] diff;
  logic [63:0] vsum;
  logic [48:0] term49;
  logic [37:0] fl_sum;
  logic [37:0] fl_c;
  logic        above;
  logic [3:0]  msb;
  logic [20:0] neg;
  logic [3:0]  pw_n;
  logic [32:0] pw_sum;
  logic [15:0] pw_p;
  logic [16:0] alpha;
  logic [64:0] g_sum;
  logic [16:0] wsum;
  logic [15:0] s_avg;

  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;
  logic        dv_start;
  logic        dv_done;
  logic [15:0] dv_q;

  ssg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x_in  (vsum),
    .done  (sq_done),
    .root  (sq_root)
  );

  ssg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (mag_r - fl_c[31:0]),
    .den   (mag_r),
    .done  (dv_done),
    .quot  (dv_q)
  );

  // Minimum gain by confidence, oversized registers act as unity.
  always_comb begin
    noisy = conf_r <= ssg_pkg::CONF_NOISE;
    if (conf_r >= ssg_pkg::CONF_SPEECH) begin
      mg_raw = cfg.min_gain_speech;
    end else if (noisy) begin
      mg_raw = cfg.min_gain_noise;
    end else begin
      mg_raw = cfg.min_gain_default;
    end
    min_g = (mg_raw > ssg_pkg::GAIN_ONE) ? ssg_pkg::GAIN_ONE : mg_raw;
  end

  always_comb begin
    diff   = (mag_r >= mean_r) ? mag_r - mean_r : mean_r - mag_r;
    vsum   = (var_r > ~ssg_pkg::VAR_EPS) ? '1 : var_r + ssg_pkg::VAR_EPS;
    term49 = {1'b0, prod_r[47:0]} + 49'd2048;
    fl_sum = 38'(mean_r) + 38'(term49[48:12]);
    fl_c   = (fl_sum == '0) ? 38'd1 : fl_sum;
    above  = 38'(mag_r) > fl_c;
    msb    = '0;
    for (int b = 0; b < 16; b++) begin
      if (dv_q[b]) msb = 4'(b);
    end
    neg    = 21'h100000 - 21'(lg_r);
    pw_n   = t_r[19:16];
    pw_sum = 33'(v_r) + (33'd1 << (5'd14 + 5'(pw_n)));
    pw_p   = 16'(pw_sum >> (5'd15 + 5'(pw_n)));
    if (target_r >= held_r) begin
      alpha = {1'b0, cfg.release_weight};
    end else begin
      alpha = (conf_r > ssg_pkg::CONF_HALF) ? ssg_pkg::ALPHA_FAST : ssg_pkg::ALPHA_SLOW;
    end
    g_sum  = tmp_r + prod_r + 65'd32768;
    wsum   = 17'(wp0_r) + 17'(wp1_r) + 17'(g_r) + 17'd1;
    s_avg  = prod_r[32:17];
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M1: begin
        mul_a = 33'(cfg.noise_decay);
        mul_b = mean_r;
      end
      S_M2: begin
        mul_a = 33'(ssg_pkg::Q16_ONE - 17'(cfg.noise_decay));
        mul_b = mag_r;
      end
      S_M4: begin
        mul_a = 33'(diff);
        mul_b = diff;
      end
      S_M5: begin
        mul_a = 33'(cfg.variance_decay);
        mul_b = var_r[63:32];
      end
      S_M6: begin
        mul_a = 33'(cfg.variance_decay);
        mul_b = var_r[31:0];
      end
      S_M7: begin
        mul_a = 33'(ssg_pkg::Q16_ONE - 17'(cfg.variance_decay));
        mul_b = d2_r[63:32];
      end
      S_M8: begin
        mul_a = 33'(ssg_pkg::Q16_ONE - 17'(cfg.variance_decay));
        mul_b = d2_r[31:0];
      end
      S_SQW: begin
        mul_a = 33'(cfg.sigma_scale);
        mul_b = sq_root;
      end
      S_LG1: begin
        mul_a = 33'(x_r);
        mul_b = x_r;
      end
      S_PW0: begin
        mul_a = 33'(ssg_pkg::POW_EXP);
        mul_b = 32'(neg);
      end
      S_EX1: begin
        mul_a = 33'(v_r);
        mul_b = EXP_C[k_r];
      end
      S_TP1: begin
        mul_a = 33'(alpha);
        mul_b = 32'(target_r);
      end
      S_TP2: begin
        mul_a = 33'(ssg_pkg::Q16_ONE - alpha);
        mul_b = 32'(held_r);
      end
      S_WN: begin
        mul_a = 33'(wsum);
        mul_b = 32'(ssg_pkg::RECIP3);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sq_start = state_r == S_SQS;
  assign dv_start = (state_r == S_FL) && above;

  // Memory write port: clearing sweep after reset, write-back at the end of a bin.
  always_comb begin
    mem_we  = (state_r == S_CLR) || (state_r == S_TP3);
    mem_wa  = (state_r == S_CLR) ? clr_r : bin_r;
    mean_wd = (state_r == S_CLR) ? ssg_pkg::MEAN_RESET : mean_r;
    var_wd  = (state_r == S_CLR) ? '0 : var_r;
    held_wd = (state_r == S_CLR) ? ssg_pkg::GAIN_ONE : g_sum[31:16];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mean_mem[mem_wa] <= mean_wd;
      var_mem[mem_wa]  <= var_wd;
      held_mem[mem_wa] <= held_wd;
    end
    mean_q <= mean_mem[bin_r];
    var_q  <= var_mem[bin_r];
    held_q <= held_mem[bin_r];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      bin_r   <= '0;
      wp0_r   <= '0;
      wp1_r   <= '0;
      rcnt_r  <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == LAST_BIN) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            mag_r   <= mag_in;
            conf_r  <= conf_in;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          mean_r  <= mean_q;
          var_r   <= var_q;
          held_r  <= held_q;
          state_r <= noisy ? S_M1 : S_SQS;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          tmp_r   <= prod_r;
          state_r <= S_M3;
        end
        S_M3: begin
          mean_r  <= g_sum[47:16];
          state_r <= S_M4;
        end
        S_M4: state_r <= S_M5;
        S_M5: begin
          d2_r    <= prod_r[63:0];
          state_r <= S_M6;
        end
        S_M6: begin
          tmp_r   <= {1'b0, prod_r[47:0], 16'b0};
          state_r <= S_M7;
        end
        S_M7: begin
          tmp_r   <= {1'b0, tmp_r[63:0] + 64'(prod_r[64:16])};
          state_r <= S_M8;
        end
        S_M8: begin
          tmp_r   <= {1'b0, tmp_r[63:0] + {prod_r[47:0], 16'b0}};
          state_r <= S_M9;
        end
        S_M9: begin
          var_r   <= tmp_r[63:0] + 64'(prod_r[64:16]);
          state_r <= S_SQS;
        end
        S_SQS: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) state_r <= S_FL;
        end
        S_FL: begin
          if (above) begin
            state_r <= S_DVW;
          end else begin
            target_r <= min_g;
            state_r  <= S_TP1;
          end
        end
        S_DVW: begin
          if (dv_done) begin
            if (dv_q == '0) begin
              target_r <= min_g;
              state_r  <= S_TP1;
            end else begin
              x_r     <= 32'(dv_q) << (5'd30 - 5'(msb));
              lg_r    <= {msb, 16'b0};
              k_r     <= '0;
              state_r <= S_LG1;
            end
          end
        end
        S_LG1: state_r <= S_LG2;
        S_LG2: begin
          if (prod_r[61]) begin
            x_r <= {1'b0, prod_r[61:31]};
            lg_r[4'd15 - k_r] <= 1'b1;
          end else begin
            x_r <= prod_r[61:30];
          end
          k_r     <= k_r + 4'd1;
          state_r <= (k_r == 4'd15) ? S_PW0 : S_LG1;
        end
        S_PW0: state_r <= S_PW1;
        S_PW1: begin
          t_r     <= 20'((prod_r[36:0] + 37'd32768) >> 16);
          v_r     <= 32'd1 << 30;
          k_r     <= '0;
          state_r <= S_EX1;
        end
        S_EX1: state_r <= S_EX2;
        S_EX2: begin
          if (t_r[4'd15 - k_r]) v_r <= prod_r[61:30];
          k_r     <= k_r + 4'd1;
          state_r <= (k_r == 4'd15) ? S_PW2 : S_EX1;
        end
        S_PW2: begin
          target_r <= (pw_p > min_g) ? pw_p : min_g;
          state_r  <= S_TP1;
        end
        S_TP1: state_r <= S_TP2;
        S_TP2: begin
          tmp_r   <= prod_r;
          state_r <= S_TP3;
        end
        S_TP3: begin
          g_r     <= g_sum[31:16];
          state_r <= S_WN;
        end
        S_WN: state_r <= S_WD;
        S_WD: begin
          if (bin_r >= BW'(2)) begin
            res_r[0].gain      <= s_avg;
            res_r[0].bin_index <= 9'(bin_r - BW'(1));
            res_r[0].last      <= 1'b0;
            res_r[1].gain      <= g_r;
            res_r[1].bin_index <= 9'(bin_r);
            res_r[1].last      <= 1'b1;
            rcnt_r <= (bin_r == LAST_BIN) ? 2'd2 : 2'd1;
          end else begin
            res_r[0].gain      <= g_r;
            res_r[0].bin_index <= 9'(bin_r);
            res_r[0].last      <= 1'b0;
            res_r[1]           <= res_r[1];
            rcnt_r <= (bin_r == '0) ? 2'd1 : 2'd0;
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (space >= rcnt_r) begin
            wp0_r   <= wp1_r;
            wp1_r   <= g_r;
            bin_r   <= (bin_r == LAST_BIN) ? '0 : bin_r + BW'(1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ready    = state_r == S_IDLE;
  assign push     = (state_r == S_PUSH) && (space >= rcnt_r);
  assign push_cnt = rcnt_r;
  assign res      = res_r;

endmodule

`default_nettype wire

// ===== src/spectral_suppression_gain.sv =====
// ----------------------------------------------------------------------------
// spectral_suppression_gain: per-bin suppression gain with noise tracking
// Top level: configuration registers, bin sequencer and a two-entry result queue.
// ----------------------------------------------------------------------------
// Usage. Bins of one frame enter on in_ch in order 0 .. NUM_BINS-1, one beat
// per bin, each with the frame's voice confidence. Gains leave on out_ch. Bin 0
// gives its own gain, bin 1 gives nothing, every later bin gives the 3-bin
// averaged gain of the bin before it, and the last bin gives that and then its
// own gain with last set.
// A bin's time in the block is set by the 32-step square root, run for every
// bin, the 16-step divider, run above the floor, and the two 16-step loops
// (log squaring, exponent build), run when the ratio is nonzero, all beside
// the noise update of noisy bins on the single shared multiplier. The next
// beat can be accepted in the cycle after a bin's results enter the queue;
// in_ch.ready is high only between bins.
// After reset the block sweeps its per-bin memories to their start values, one
// bin a cycle, over all NUM_BINS bins with ready low; configuration writes are
// taken at any time, but belong in the gaps between frames or bins.
// Results wait in a two-entry queue, so a stalled receiver does not block the
// next bin from being accepted until the queue fills; a bin finishes only once
// the queue has room for all of its results.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_suppression_gain #(
  parameter int NUM_BINS = 257
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ssg_in_if.sink           in_ch,
  ssg_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  ssg_pkg::ssg_cfg_t cfg_r;
  ssg_pkg::ssg_res_t q_r [2];
  ssg_pkg::ssg_res_t q_nxt [2];
  ssg_pkg::ssg_res_t core_res [2];
  logic [1:0]        qcnt_r;
  logic [1:0]        qcnt_nxt;
  logic              core_ready;
  logic              core_push;
  logic [1:0]        core_cnt;
  logic              pop;
  logic [1:0]        space;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gain_speech  <= ssg_pkg::CFG_RST_MGS;
      cfg_r.min_gain_default <= ssg_pkg::CFG_RST_MGD;
      cfg_r.min_gain_noise   <= ssg_pkg::CFG_RST_MGN;
      cfg_r.noise_decay      <= ssg_pkg::CFG_RST_ND;
      cfg_r.variance_decay   <= ssg_pkg::CFG_RST_VD;
      cfg_r.sigma_scale      <= ssg_pkg::CFG_RST_SIG;
      cfg_r.release_weight   <= ssg_pkg::CFG_RST_RW;
    end else if (cfg_we) begin
      unique case (ssg_pkg::cfg_idx_t'(cfg_addr))
        ssg_pkg::CFG_MIN_GAIN_SPEECH:  cfg_r.min_gain_speech  <= cfg_wdata;
        ssg_pkg::CFG_MIN_GAIN_DEFAULT: cfg_r.min_gain_default <= cfg_wdata;
        ssg_pkg::CFG_MIN_GAIN_NOISE:   cfg_r.min_gain_noise   <= cfg_wdata;
        ssg_pkg::CFG_NOISE_DECAY:      cfg_r.noise_decay      <= cfg_wdata;
        ssg_pkg::CFG_VARIANCE_DECAY:   cfg_r.variance_decay   <= cfg_wdata;
        ssg_pkg::CFG_SIGMA_SCALE:      cfg_r.sigma_scale      <= cfg_wdata;
        ssg_pkg::CFG_RELEASE_WEIGHT:   cfg_r.release_weight   <= cfg_wdata;
        default:                       cfg_r                  <= cfg_r;
      endcase
    end
  end

  ssg_core #(
    .NUM_BINS (NUM_BINS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_ch.valid && core_ready),
    .mag_in   (in_ch.magnitude),
    .conf_in  (in_ch.voice_confidence),
    .cfg      (cfg_r),
    .space    (space),
    .ready    (core_ready),
    .push     (core_push),
    .push_cnt (core_cnt),
    .res      (core_res)
  );

  assign in_ch.ready = core_ready;

  // Result queue: the head beat is shown on out_ch; the core appends up to two
  // beats at once, and only when the queue has room for them without a pop.
  assign pop   = out_ch.valid && out_ch.ready;
  assign space = 2'd2 - qcnt_r;

  always_comb begin
    logic [1:0] c;
    logic [1:0] pos;
    q_nxt = q_r;
    c     = qcnt_r;
    pos   = '0;
    if (pop) begin
      q_nxt[0] = q_r[1];
      c        = c - 2'd1;
    end
    qcnt_nxt = c;
    if (core_push) begin
      for (int j = 0; j < 2; j++) begin
        if (2'(j) < core_cnt) begin
          pos = c + 2'(j);
          q_nxt[pos[0]] = core_res[j];
        end
      end
      qcnt_nxt = c + core_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_ch.valid     = qcnt_r != 2'd0;
  assign out_ch.gain      = q_r[0].gain;
  assign out_ch.bin_index = q_r[0].bin_index;
  assign out_ch.last      = q_r[0].last;

endmodule

`default_nettype wire

// ===== tb/spectral_suppression_gain_tb.sv =====
// ----------------------------------------------------------------------------
// spectral_suppression_gain_tb: self-checking bench of the suppression gain
// Feeds frames of bins through randomized valid/ready handshakes, predicts every
// gain with an independent bit-true model of the noise tracker and gain path,
// and compares each output beat field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spectral_suppression_gain_tb;

  localparam int          NBINS      = 257;
  localparam int          LIMIT      = 1000000;
  localparam logic [2:0]  CFG_UNUSED = 3'd7;   // index with no register behind it
  localparam logic [15:0] CONF_MAX   = 16'hFFFF;

  typedef struct {
    logic [31:0] mag;
    logic [15:0] conf;
  } bin_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  ssg_in_if  in_bus ();
  ssg_out_if out_bus ();

  spectral_suppression_gain #(.NUM_BINS(NBINS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Bins waiting to be driven, and gains the block still owes us.
  bin_beat_t          bins_pending[$];
  ssg_pkg::ssg_res_t  gains_owed[$];
  int                 err_count;
  int                 beats_taken;
  int                 cycle_count;
  int                 send_idle;
  int                 recv_stall;

  // Shadow copy of the registers and the per-bin state of the block.
  logic [15:0] mg_speech, mg_default, mg_noise, decay_mean, decay_var, sigma_k, rel_w;
  logic [31:0] mean_sh [NBINS];
  logic [63:0] var_sh  [NBINS];
  logic [15:0] held_sh [NBINS];
  logic [31:0] win_a, win_b;
  int          bin_pos;
  logic [31:0] learned_mag [NBINS];

  always #5 clk = ~clk;

  // Integer square root, rounded down.
  function automatic logic [63:0] root_floor(input logic [63:0] x_in);
    logic [63:0] x, r, b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor(w * x / 65536) split into halves so that only the top part wraps.
  function automatic logic [63:0] weigh_q16(input logic [63:0] w, input logic [63:0] x);
    return ((w * (x >> 32)) << 16) + ((w * (x & 64'hFFFF_FFFF)) >> 16);
  endfunction

  // (r/65536)^0.92 in Q1.15 via a log2 by squaring and an exp2 from root constants.
  function automatic logic [31:0] ratio_pow(input logic [31:0] r);
    int          n;
    logic [63:0] x, lg, neg, t, v, c;
    n = 0;
    while ((r >> (n + 1)) != 0) n++;
    x  = 64'(r) << (30 - n);
    lg = 64'(n) << 16;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        lg = lg | (64'd1 << (15 - k));
      end
    end
    neg = (64'd16 << 16) - lg;
    t   = (64'd60293 * neg + 64'd32768) >> 16;
    n   = int'(t >> 16);
    v   = 64'd1 << 30;
    c   = root_floor(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      if (t[15 - k]) v = (v * c) >> 30;
      c = root_floor(c << 30);
    end
    if (n > 40) return 32'd0;
    return 32'((v + (64'd1 << (14 + n))) >> (15 + n));
  endfunction

  function automatic logic [31:0] cap_gain(input logic [15:0] g);
    return (g > ssg_pkg::GAIN_ONE) ? 32'(ssg_pkg::GAIN_ONE) : 32'(g);
  endfunction

  // Advances the shadow state by one bin and queues the gains it releases.
  task automatic predict_bin(input logic [31:0] mag, input logic [15:0] conf);
    logic [31:0]       floor_min, target, alpha, g, ratio, p;
    logic [63:0]       d, vsum, dev, nfloor;
    ssg_pkg::ssg_res_t res;
    int                b;
    b = bin_pos;
    if (conf >= ssg_pkg::CONF_SPEECH)     floor_min = cap_gain(mg_speech);
    else if (conf <= ssg_pkg::CONF_NOISE) floor_min = cap_gain(mg_noise);
    else                                  floor_min = cap_gain(mg_default);

    // Noise tracking runs only on bins that look like noise.
    if (conf <= ssg_pkg::CONF_NOISE) begin
      mean_sh[b] = 32'((64'(decay_mean) * mean_sh[b] + (64'd65536 - decay_mean) * mag
                        + 64'd32768) >> 16);
      d = (mag >= mean_sh[b]) ? 64'(mag - mean_sh[b]) : 64'(mean_sh[b] - mag);
      var_sh[b] = weigh_q16(64'(decay_var), var_sh[b])
                + weigh_q16(64'd65536 - decay_var, d * d);
    end

    vsum   = (var_sh[b] > ~64'd0 - ssg_pkg::VAR_EPS) ? ~64'd0 : var_sh[b] + ssg_pkg::VAR_EPS;
    dev    = root_floor(vsum);
    nfloor = 64'(mean_sh[b]) + ((64'(sigma_k) * dev + 64'd2048) >> 12);
    if (nfloor < 1) nfloor = 1;

    target = floor_min;
    if (64'(mag) > nfloor) begin
      ratio = 32'(((64'(mag) - nfloor) << 16) / mag);
      if (ratio != 0) begin
        p = ratio_pow(ratio);
        if (p > target) target = p;
      end
    end

    // Fast release toward a higher gain, slower attack toward a lower one.
    if (target >= held_sh[b]) alpha = rel_w;
    else alpha = (conf > ssg_pkg::CONF_HALF) ? 32'(ssg_pkg::ALPHA_FAST)
                                             : 32'(ssg_pkg::ALPHA_SLOW);
    g = 32'((64'(alpha) * target + 64'(32'd65536 - alpha) * held_sh[b] + 64'd32768) >> 16);
    held_sh[b] = g[15:0];

    if (b >= 2) begin
      res.gain      = 16'((win_a + win_b + g + 1) / 3);
      res.bin_index = 9'(b - 1);
      res.last      = 1'b0;
      gains_owed.push_back(res);
    end
    if (b == 0 || b == NBINS - 1) begin
      res.gain      = g[15:0];
      res.bin_index = 9'(b);
      res.last      = (b == NBINS - 1);
      gains_owed.push_back(res);
    end
    win_a   = win_b;
    win_b   = g;
    bin_pos = (b == NBINS - 1) ? 0 : b + 1;
  endtask

  // One register write on the plain write port, mirrored into the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      ssg_pkg::CFG_MIN_GAIN_SPEECH:  mg_speech  = val;
      ssg_pkg::CFG_MIN_GAIN_DEFAULT: mg_default = val;
      ssg_pkg::CFG_MIN_GAIN_NOISE:   mg_noise   = val;
      ssg_pkg::CFG_NOISE_DECAY:      decay_mean = val;
      ssg_pkg::CFG_VARIANCE_DECAY:   decay_var  = val;
      ssg_pkg::CFG_SIGMA_SCALE:      sigma_k    = val;
      ssg_pkg::CFG_RELEASE_WEIGHT:   rel_w      = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until the block has drained, then leaves room for a bin that is still
  // being worked on but releases no gain (bin 1 of a frame).
  task automatic wait_drained();
    wait (bins_pending.size() == 0 && !in_bus.valid && gains_owed.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_mag();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(32'd4096);
      3:       return $urandom_range(32'd1 << 22);
      4:       return $urandom_range(32'd1 << 26);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_conf();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return CONF_MAX;
      2:       return ssg_pkg::CONF_NOISE;
      3:       return ssg_pkg::CONF_NOISE + 16'd1;
      4:       return ssg_pkg::CONF_SPEECH;
      5:       return ssg_pkg::CONF_SPEECH - 16'd1;
      6:       return ssg_pkg::CONF_HALF;
      7:       return ssg_pkg::CONF_HALF + 16'd1;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Queues a frame, or a tail of one, with a frame-wide confidence; now and then
  // the confidence varies bin by bin.
  task automatic queue_random(input int count);
    logic [15:0] conf;
    bit          varying;
    bin_beat_t   bt;
    conf    = rand_conf();
    varying = ($urandom_range(9) == 0);
    for (int k = 0; k < count; k++) begin
      bt.mag  = rand_mag();
      bt.conf = varying ? rand_conf() : conf;
      bins_pending.push_back(bt);
    end
  endtask

  task automatic queue_bin(input logic [31:0] mag, input logic [15:0] conf);
    bin_beat_t bt;
    bt.mag  = mag;
    bt.conf = conf;
    bins_pending.push_back(bt);
  endtask

  // Driver: presents queued bins, idling at random; the beat is predicted when
  // it is taken. Idle pattern changes every 64 accepted beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid            <= 1'b0;
      in_bus.magnitude        <= '0;
      in_bus.voice_confidence <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_bin(in_bus.magnitude, in_bus.voice_confidence);
        beats_taken++;
      end
      case ((beats_taken / 64) % 4)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 51; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      if (!in_bus.valid || in_bus.ready) begin
        if (bins_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_bus.valid            <= 1'b1;
          in_bus.magnitude        <= bins_pending[0].mag;
          in_bus.voice_confidence <= bins_pending[0].conf;
          void'(bins_pending.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output at random and checks each gain beat in order.
  always @(posedge clk) begin
    ssg_pkg::ssg_res_t want;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (gains_owed.size() == 0) begin
          $error("gain beat for bin %0d with nothing expected", out_bus.bin_index);
          err_count++;
        end else begin
          want = gains_owed.pop_front();
          if (out_bus.gain !== want.gain) begin
            $error("gain: expected %0d, got %0d", want.gain, out_bus.gain);
            err_count++;
          end
          if (out_bus.bin_index !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, out_bus.bin_index);
            err_count++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_bus.last);
            err_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_addr                = '0;
    cfg_wdata               = '0;
    in_bus.valid            = 1'b0;
    in_bus.magnitude        = '0;
    in_bus.voice_confidence = '0;
    out_bus.ready           = 1'b0;
    err_count   = 0;
    beats_taken = 0;
    cycle_count = 0;
    send_idle   = 0;
    recv_stall  = 0;

    // Shadow state starts where the block's reset leaves it.
    mg_speech  = ssg_pkg::CFG_RST_MGS;
    mg_default = ssg_pkg::CFG_RST_MGD;
    mg_noise   = ssg_pkg::CFG_RST_MGN;
    decay_mean = ssg_pkg::CFG_RST_ND;
    decay_var  = ssg_pkg::CFG_RST_VD;
    sigma_k    = ssg_pkg::CFG_RST_SIG;
    rel_w      = ssg_pkg::CFG_RST_RW;
    for (int k = 0; k < NBINS; k++) begin
      mean_sh[k] = ssg_pkg::MEAN_RESET;
      var_sh[k]  = '0;
      held_sh[k] = ssg_pkg::GAIN_ONE;
    end
    win_a   = 0;
    win_b   = 0;
    bin_pos = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Frame one, reset settings: field extremes, every confidence band and its
    // edges, then random bins to close the frame.
    queue_bin(32'd0,          16'd0);
    queue_bin(32'hFFFF_FFFF,  CONF_MAX);
    queue_bin(32'd1,          ssg_pkg::CONF_NOISE);
    queue_bin(32'd16,         ssg_pkg::CONF_NOISE + 16'd1);
    queue_bin(32'd17,         ssg_pkg::CONF_SPEECH - 16'd1);
    queue_bin(32'd1 << 20,    ssg_pkg::CONF_SPEECH);
    queue_bin(32'hFFFF_FFFF,  16'd0);
    queue_bin(32'h8000_0000,  ssg_pkg::CONF_HALF);
    queue_bin(32'h7FFF_FFFF,  ssg_pkg::CONF_HALF + 16'd1);
    queue_bin(32'h5555_5555,  16'h5555);
    queue_bin(32'hAAAA_AAAA,  16'hAAAA);
    queue_bin(32'd1 << 20,    16'd0);
    queue_bin(32'd0,          CONF_MAX);
    queue_bin(32'd100,        16'd0);
    queue_bin(32'd1 << 30,    16'd0);
    queue_bin(32'd3,          ssg_pkg::CONF_SPEECH);
    queue_random(NBINS - 16);
    wait_drained();

    // Extreme settings: oversized speech minimum, mean follows input exactly,
    // variance nearly frozen, no deviation term, gain held on rises. The stray write
    // to an unused index must change nothing.
    write_reg(ssg_pkg::CFG_MIN_GAIN_SPEECH,  16'hFFFF);
    write_reg(ssg_pkg::CFG_MIN_GAIN_DEFAULT, ssg_pkg::GAIN_ONE);
    write_reg(ssg_pkg::CFG_MIN_GAIN_NOISE,   16'd0);
    write_reg(ssg_pkg::CFG_NOISE_DECAY,      16'd0);
    write_reg(ssg_pkg::CFG_VARIANCE_DECAY,   16'hFFFF);
    write_reg(ssg_pkg::CFG_SIGMA_SCALE,      16'd0);
    write_reg(ssg_pkg::CFG_RELEASE_WEIGHT,   16'd0);
    write_reg(CFG_UNUSED,                    16'h1234);
    end_writes();

    // A noise frame teaches every bin its magnitude as the floor.
    for (int k = 0; k < NBINS; k++) begin
      learned_mag[k] = $urandom_range(32'd1 << 26, 32'd1 << 17);
      queue_bin(learned_mag[k], 16'd0);
    end
    wait_drained();

    // Start of a speech frame barely above the learned floor: the ratio
    // truncates to zero for most bins, so the minimum gain decides.
    write_reg(ssg_pkg::CFG_RELEASE_WEIGHT, 16'hFFFF);
    end_writes();
    for (int k = 0; k < 20; k++) begin
      if ($urandom_range(7) == 0) queue_bin(rand_mag(), CONF_MAX);
      else queue_bin(learned_mag[k] + $urandom_range(3, 1), CONF_MAX);
    end
    wait_drained();

    // Opposite extremes, then a short random stretch.
    write_reg(ssg_pkg::CFG_MIN_GAIN_SPEECH,  ssg_pkg::GAIN_ONE);
    write_reg(ssg_pkg::CFG_MIN_GAIN_DEFAULT, 16'd0);
    write_reg(ssg_pkg::CFG_MIN_GAIN_NOISE,   ssg_pkg::GAIN_ONE + 16'd1);
    write_reg(ssg_pkg::CFG_NOISE_DECAY,      16'hFFFF);
    write_reg(ssg_pkg::CFG_VARIANCE_DECAY,   16'd0);
    write_reg(ssg_pkg::CFG_SIGMA_SCALE,      16'hFFFF);
    end_writes();
    queue_random(10);
    queue_random(10);

    wait (bins_pending.size() == 0 && !in_bus.valid && gains_owed.size() == 0);
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
